/* src/ptls_pkg.sv */
// Package for the pedestrian traffic light sequencer.
// Holds phase codes, register indexes, reset values and shared types.
// No dependencies.
package ptls_pkg;

   localparam logic [2:0] PHASE_GREEN = 3'd0;
   localparam logic [2:0] PHASE_YELLOW = 3'd1;
   localparam logic [2:0] PHASE_RED = 3'd2;
   localparam logic [2:0] PHASE_WARN = 3'd3;
   localparam logic [2:0] PHASE_WALK = 3'd4;
   localparam logic [2:0] PHASE_CLEAR = 3'd5;

   localparam logic [2:0] CSR_GREEN_TICKS = 3'd0;
   localparam logic [2:0] CSR_RED_TICKS = 3'd1;
   localparam logic [2:0] CSR_WALK_TICKS = 3'd2;
   localparam logic [2:0] CSR_BLINK_STEP_TICKS = 3'd3;
   localparam logic [2:0] CSR_BLINK_STEPS = 3'd4;
   localparam logic [2:0] CSR_LONG_PRESS_TICKS = 3'd5;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [15:0] GREEN_TICKS_RESET = 16'd250;
   localparam logic [15:0] RED_TICKS_RESET = 16'd250;
   localparam logic [15:0] WALK_TICKS_RESET = 16'd250;
   localparam logic [15:0] BLINK_STEP_TICKS_RESET = 16'd50;
   localparam logic [3:0] BLINK_STEPS_RESET = 4'd5;
   localparam logic [15:0] LONG_PRESS_TICKS_RESET = 16'd100;

   typedef struct packed {
      logic [15:0] green_ticks;
      logic [15:0] red_ticks;
      logic [15:0] walk_ticks;
      logic [15:0] blink_step_ticks;
      logic [3:0] blink_steps;
      logic [15:0] long_press_ticks;
   } cfg_type;

   typedef struct packed {
      logic [2:0] phase;
      logic [3:0] toggle_count;
      logic yellow_level;
      logic [15:0] hold_count;
      logic request_pending;
   } state_type;

   typedef struct packed {
      logic car_green;
      logic car_yellow;
      logic car_red;
      logic walk_green;
      logic walk_yellow;
      logic walk_red;
      logic [2:0] phase_code;
   } lamps_type;

   function automatic logic is_blink(input logic [2:0] phase);
      return (phase == PHASE_YELLOW) || (phase == PHASE_WARN) || (phase == PHASE_CLEAR);
   endfunction

   function automatic logic [2:0] next_phase(input logic [2:0] phase);
      logic [2:0] result;
      case (phase)
         PHASE_GREEN: result = PHASE_YELLOW;
         PHASE_YELLOW: result = PHASE_RED;
         PHASE_WARN: result = PHASE_WALK;
         PHASE_WALK: result = PHASE_CLEAR;
         default: result = PHASE_GREEN;
      endcase
      return result;
   endfunction

endpackage

/* src/ptls_step.sv */
// Next-state and lamp logic for one sampled tick and button level.
// Depends on ptls_pkg for the state, configuration and lamp types.
module ptls_step #(
   parameter int TICK_COUNT_BITS = 16
) (
   input ptls_pkg::cfg_type cfg,
   input ptls_pkg::state_type st,
   input logic [TICK_COUNT_BITS-1:0] phase_ticks,
   input logic tick,
   input logic button_pressed,
   output ptls_pkg::state_type st_next,
   output logic [TICK_COUNT_BITS-1:0] phase_ticks_next,
   output ptls_pkg::lamps_type lamps
);
   import ptls_pkg::*;

   localparam int CMP_BITS = (TICK_COUNT_BITS + 1 > 16) ? TICK_COUNT_BITS + 1 : 16;

   logic normal;
   logic [16:0] hold_sum;
   logic [TICK_COUNT_BITS:0] elapsed;
   logic [15:0] limit;
   logic [3:0] steps;
   logic step_more;
   logic enter;
   logic [2:0] target;

   assign normal = st.phase <= PHASE_RED;
   assign hold_sum = {1'b0, st.hold_count} + 17'(st.hold_count == 16'd0) + 17'(tick);
   assign elapsed = {1'b0, phase_ticks} + {{TICK_COUNT_BITS{1'b0}}, 1'b1};
   assign steps = (cfg.blink_steps == 4'd0) ? 4'd1 : cfg.blink_steps;
   assign step_more = (CMP_BITS'(elapsed) < CMP_BITS'(limit)) && !elapsed[TICK_COUNT_BITS];

   always_comb begin
      case (st.phase)
         PHASE_RED: limit = cfg.red_ticks;
         PHASE_WALK: limit = cfg.walk_ticks;
         PHASE_YELLOW, PHASE_WARN, PHASE_CLEAR: limit = cfg.blink_step_ticks;
         default: limit = cfg.green_ticks;
      endcase
   end

   always_comb begin
      st_next = st;
      phase_ticks_next = phase_ticks;
      enter = 1'b0;
      target = next_phase(st.phase);

      if (button_pressed) begin
         st_next.hold_count = hold_sum[16] ? 16'hFFFF : hold_sum[15:0];
      end else if (st.hold_count != 16'd0) begin
         if (normal && (st.hold_count - 16'd1 <= cfg.long_press_ticks)) begin
            st_next.request_pending = 1'b1;
         end
         st_next.hold_count = 16'd0;
      end

      if (st_next.request_pending && normal) begin
         st_next.request_pending = 1'b0;
         enter = 1'b1;
         target = (st.phase == PHASE_RED) ? PHASE_WALK : PHASE_WARN;
      end else if (tick) begin
         if (step_more) begin
            phase_ticks_next = elapsed[TICK_COUNT_BITS-1:0];
         end else begin
            phase_ticks_next = '0;
            if (is_blink(st.phase) && (st.toggle_count < steps)) begin
               st_next.yellow_level = !st.yellow_level;
               st_next.toggle_count = st.toggle_count + 4'd1;
            end else begin
               enter = 1'b1;
            end
         end
      end

      if (enter) begin
         st_next.phase = target;
         phase_ticks_next = '0;
         st_next.yellow_level = is_blink(target);
         st_next.toggle_count = {3'b000, is_blink(target)};
      end
   end

   always_comb begin
      lamps = '0;
      lamps.phase_code = st_next.phase;
      case (st_next.phase)
         PHASE_YELLOW: begin
            lamps.car_yellow = st_next.yellow_level;
            lamps.walk_red = 1'b1;
         end
         PHASE_RED: begin
            lamps.car_red = 1'b1;
            lamps.walk_red = 1'b1;
         end
         PHASE_WARN: begin
            lamps.car_yellow = st_next.yellow_level;
            lamps.walk_yellow = st_next.yellow_level;
            lamps.walk_red = 1'b1;
         end
         PHASE_WALK: begin
            lamps.car_red = 1'b1;
            lamps.walk_green = 1'b1;
         end
         PHASE_CLEAR: begin
            lamps.car_yellow = st_next.yellow_level;
            lamps.walk_yellow = st_next.yellow_level;
            lamps.walk_green = 1'b1;
         end
         default: begin
            lamps.car_green = 1'b1;
            lamps.walk_red = 1'b1;
         end
      endcase
   end

endmodule

/* src/pedestrian_traffic_light_sequencer_top.sv */
// Top level of the pedestrian traffic light sequencer: registers, handshakes, CSRs.
// Depends on ptls_pkg and ptls_step.
//
//   Channel  Ports                         Direction  Moves
//   req      req_valid/req_ready           in         tick strobe and button level
//   rsp      rsp_valid/rsp_ready           out        six lamps and phase code
//   csr      csr_write_en/index/write_data in         one timing register per write
//
// Each request transfer is processed by the combinational step logic and lands in the
// response register, so one transfer per cycle is sustained while rsp_ready is high.
// A new request is taken whenever the response register is empty or being drained.
// Reset restores the default timing registers and starts in the car green phase.
module pedestrian_traffic_light_sequencer_top #(
   parameter int TICK_COUNT_BITS = 16
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input logic req_tick,
   input logic req_button_pressed,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic rsp_car_green,
   output logic rsp_car_yellow,
   output logic rsp_car_red,
   output logic rsp_walk_green,
   output logic rsp_walk_yellow,
   output logic rsp_walk_red,
   output logic [2:0] rsp_phase_code,
   input logic csr_write_en,
   input logic [ptls_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input logic [ptls_pkg::CSR_DATA_BITS-1:0] csr_write_data
);
   import ptls_pkg::*;

   cfg_type cfg_ff;
   state_type st_ff;
   state_type st_in;
   logic [TICK_COUNT_BITS-1:0] ticks_ff;
   logic [TICK_COUNT_BITS-1:0] ticks_in;
   lamps_type lamps_ff;
   lamps_type lamps_in;
   logic rsp_valid_ff;
   logic req_transfer;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_transfer = req_valid && req_ready;

   ptls_step #(
      .TICK_COUNT_BITS(TICK_COUNT_BITS)
   ) u_step (
      .cfg(cfg_ff),
      .st(st_ff),
      .phase_ticks(ticks_ff),
      .tick(req_tick),
      .button_pressed(req_button_pressed),
      .st_next(st_in),
      .phase_ticks_next(ticks_in),
      .lamps(lamps_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.green_ticks <= GREEN_TICKS_RESET;
         cfg_ff.red_ticks <= RED_TICKS_RESET;
         cfg_ff.walk_ticks <= WALK_TICKS_RESET;
         cfg_ff.blink_step_ticks <= BLINK_STEP_TICKS_RESET;
         cfg_ff.blink_steps <= BLINK_STEPS_RESET;
         cfg_ff.long_press_ticks <= LONG_PRESS_TICKS_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_GREEN_TICKS: cfg_ff.green_ticks <= csr_write_data;
            CSR_RED_TICKS: cfg_ff.red_ticks <= csr_write_data;
            CSR_WALK_TICKS: cfg_ff.walk_ticks <= csr_write_data;
            CSR_BLINK_STEP_TICKS: cfg_ff.blink_step_ticks <= csr_write_data;
            CSR_BLINK_STEPS: cfg_ff.blink_steps <= csr_write_data[3:0];
            CSR_LONG_PRESS_TICKS: cfg_ff.long_press_ticks <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '{phase: PHASE_GREEN, default: '0};
         ticks_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_transfer) begin
            st_ff <= st_in;
            ticks_ff <= ticks_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         lamps_ff <= lamps_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_car_green = lamps_ff.car_green;
   assign rsp_car_yellow = lamps_ff.car_yellow;
   assign rsp_car_red = lamps_ff.car_red;
   assign rsp_walk_green = lamps_ff.walk_green;
   assign rsp_walk_yellow = lamps_ff.walk_yellow;
   assign rsp_walk_red = lamps_ff.walk_red;
   assign rsp_phase_code = lamps_ff.phase_code;

   a_request_consumed: assert property (@(posedge clock) disable iff (reset)
      !st_ff.request_pending)
      else $error("pedestrian request left pending");

   a_blink_count: assert property (@(posedge clock) disable iff (reset)
      is_blink(st_ff.phase) |-> st_ff.toggle_count != 4'd0)
      else $error("blink phase without a toggle counted");

   a_steady_dark: assert property (@(posedge clock) disable iff (reset)
      !is_blink(st_ff.phase) |-> (st_ff.toggle_count == 4'd0) && !st_ff.yellow_level)
      else $error("yellow state active outside a blink phase");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_transfer |=> rsp_valid && (rsp_phase_code == st_ff.phase))
      else $error("accepted request did not produce a matching result");

endmodule
